// File: rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, limits and character codes for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int MaxTokens = 16;
  localparam int TokenLen  = 32;

  // Internal state widths follow the limits.
  localparam int PosW = $clog2(TokenLen);
  localparam int CntW = $clog2(MaxTokens + 1);

  // Fixed widths of the result fields.
  localparam int CharW   = 8;
  localparam int SlotW   = 4;
  localparam int SPosW   = 5;
  localparam int LenW    = 5;
  localparam int CountW  = 5;

  localparam logic [CharW-1:0] CharNul    = 8'h00;
  localparam logic [CharW-1:0] CharTab    = 8'h09;
  localparam logic [CharW-1:0] CharSpace  = 8'h20;
  localparam logic [CharW-1:0] CharDollar = 8'h24;
  localparam logic [CharW-1:0] CharEquals = 8'h3D;
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;

  typedef struct packed {
    logic             store_valid;
    logic [SlotW-1:0] store_slot;
    logic [SPosW-1:0] store_pos;
    logic [CharW-1:0] stored_char;
    logic             token_closed;
    logic [LenW-1:0]  closed_length;
    logic [CountW-1:0] tokens_done;
    logic             line_end;
  } clt_result_t;

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return ((c >= CharUpperA) && (c <= CharUpperZ)) ||
           ((c >= CharLowerA) && (c <= CharLowerZ));
  endfunction

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == CharSpace) || (c == CharTab);
  endfunction

endpackage

// File: rtl/clt_step.sv
// ----------------------------------------------------------------------------
// clt_step
// Tokenizer state registers and the per-character update and result logic.
// ----------------------------------------------------------------------------
module clt_step (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_en_i,
  input  logic [clt_pkg::CharW-1:0] char_i,
  output clt_pkg::clt_result_t     result_o
);
  import clt_pkg::*;

  localparam logic [PosW-1:0] PosLimit = PosW'(TokenLen - 1);
  localparam logic [CntW-1:0] CntLimit = CntW'(MaxTokens);

  logic            skip_q, skip_d;
  logic            open_q, open_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] total_q, total_d;
  logic            owl_q, owl_d;
  logic            limit_q, limit_d;

  logic [CntW-1:0] report_total;
  logic [PosW-1:0] cur_pos;
  logic            stop;
  logic            letter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q  <= 1'b1;
      open_q  <= 1'b0;
      pos_q   <= '0;
      total_q <= '0;
      owl_q   <= 1'b0;
      limit_q <= 1'b0;
    end else if (step_en_i) begin
      skip_q  <= skip_d;
      open_q  <= open_d;
      pos_q   <= pos_d;
      total_q <= total_d;
      owl_q   <= owl_d;
      limit_q <= limit_d;
    end
  end

  always_comb begin
    skip_d       = skip_q;
    open_d       = open_q;
    pos_d        = pos_q;
    total_d      = total_q;
    owl_d        = owl_q;
    limit_d      = limit_q;
    report_total = total_q;
    cur_pos      = pos_q;
    stop         = 1'b0;
    letter       = is_letter(char_i);
    result_o     = '0;

    if (char_i == CharNul) begin
      result_o.line_end = 1'b1;
      if (open_q && !limit_q) begin
        result_o.token_closed  = 1'b1;
        result_o.closed_length = LenW'(pos_q);
        report_total           = total_q + CntW'(1);
      end
      // back to the start-of-line state
      skip_d  = 1'b1;
      open_d  = 1'b0;
      pos_d   = '0;
      total_d = '0;
      owl_d   = 1'b0;
      limit_d = 1'b0;
    end else if (limit_q) begin
      // drop the rest of the line
    end else if (skip_q && (is_blank(char_i) || char_i == CharDollar ||
                            char_i == CharEquals)) begin
      // drop leading separator
    end else begin
      skip_d = 1'b0;
      if (is_blank(char_i)) begin
        if (open_q) begin
          result_o.token_closed  = 1'b1;
          result_o.closed_length = LenW'(pos_q);
          total_d                = total_q + CntW'(1);
          pos_d                  = '0;
          open_d                 = 1'b0;
          if (total_d == CntLimit) limit_d = 1'b1;
        end
      end else begin
        if (open_q && letter && owl_q) begin
          result_o.token_closed  = 1'b1;
          result_o.closed_length = LenW'(pos_q);
          total_d                = total_q + CntW'(1);
          cur_pos                = '0;
          pos_d                  = '0;
          if (total_d == CntLimit) begin
            limit_d = 1'b1;
            stop    = 1'b1;
          end
        end
        if (!stop && (cur_pos < PosLimit)) begin
          result_o.store_valid = 1'b1;
          result_o.store_slot  = SlotW'(total_d);
          result_o.store_pos   = SPosW'(cur_pos);
          result_o.stored_char = char_i;
          if (cur_pos == '0) owl_d = letter;
          pos_d  = cur_pos + PosW'(1);
          open_d = 1'b1;
        end
      end
      report_total = total_d;
    end

    result_o.tokens_done = CountW'(report_total);
  end

  a_line_end_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && result_o.line_end |=> skip_q && !open_q && total_q == '0 && !limit_q)
    else $error("state not cleared after line end");

  a_total_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntLimit)
    else $error("token count beyond limit");

  a_limit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q |-> total_q == CntLimit)
    else $error("limit flag without full token count");

  a_store_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && result_o.store_valid |=> total_q == $past(total_d) && !limit_q)
    else $error("store into slot past the limit");

endmodule

// File: rtl/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a command line into tokens, one character per item.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle while the input is not stalled, and
// returns one result per character, in order. The character goes into an
// input register, the tokenizer state is updated as the character moves
// into the output register, which holds its result. Back-to-back items
// run at full rate; input stalls only while both registers are full and
// the output is stalled.
module command_line_tokenizer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [clt_pkg::CharW-1:0]  char_code_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       store_valid_o,
  output logic [clt_pkg::SlotW-1:0]  store_slot_o,
  output logic [clt_pkg::SPosW-1:0]  store_pos_o,
  output logic [clt_pkg::CharW-1:0]  stored_char_o,
  output logic                       token_closed_o,
  output logic [clt_pkg::LenW-1:0]   closed_length_o,
  output logic [clt_pkg::CountW-1:0] tokens_done_o,
  output logic                       line_end_o
);
  import clt_pkg::*;

  logic             in_vld_q;
  logic [CharW-1:0] char_q;
  logic             out_vld_q;
  clt_result_t      res_q;
  clt_result_t      res_d;
  logic             advance;
  logic             step_en;
  logic             accept;

  assign advance    = !out_vld_q || !out_stall_i;
  assign step_en    = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (step_en) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_code_i;
    end
  end

  clt_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .char_i    (char_q),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_en) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign store_valid_o   = res_q.store_valid;
  assign store_slot_o    = res_q.store_slot;
  assign store_pos_o     = res_q.store_pos;
  assign stored_char_o   = res_q.stored_char;
  assign token_closed_o  = res_q.token_closed;
  assign closed_length_o = res_q.closed_length;
  assign tokens_done_o   = res_q.tokens_done;
  assign line_end_o      = res_q.line_end;

endmodule

// File: sim/command_line_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_tb
// Self-checking bench for the command line tokenizer. Lines of characters
// are sent through a bursty driver. A predictor tracks the tokenizer state
// and computes the expected result at each accepted item. A monitor checks
// each result against the oldest expected one while the output stalls on
// random patterns and on one long hold-off.
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb;
  import clt_pkg::*;

  typedef enum int {
    LineWords,
    LineOverlong,
    LineFull,
    LineMixed,
    LineNoise,
    LineEmpty
  } line_kind_e;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallToggle
  } stall_style_e;

  localparam int IdleLimit   = 1000;
  localparam int HoldoffAt   = 300;
  localparam int HoldoffLen  = 80;
  localparam int DrainCycles = 6;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic [CharW-1:0]    char_code_i = CharNul;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                store_valid_o;
  logic [SlotW-1:0]    store_slot_o;
  logic [SPosW-1:0]    store_pos_o;
  logic [CharW-1:0]    stored_char_o;
  logic                token_closed_o;
  logic [LenW-1:0]     closed_length_o;
  logic [CountW-1:0]   tokens_done_o;
  logic                line_end_o;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  command_line_tokenizer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .store_valid_o   (store_valid_o),
    .store_slot_o    (store_slot_o),
    .store_pos_o     (store_pos_o),
    .stored_char_o   (stored_char_o),
    .token_closed_o  (token_closed_o),
    .closed_length_o (closed_length_o),
    .tokens_done_o   (tokens_done_o),
    .line_end_o      (line_end_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [CharW-1:0] line_chars[$];
  clt_result_t      expected_results[$];
  int               item_total     = 0;
  int               accepted_count = 0;
  int               fail_count     = 0;

  // Tokenizer state as seen by the predictor
  logic              tok_leading     = 1'b1;
  logic              tok_open        = 1'b0;
  logic [LenW-1:0]   tok_len         = '0;
  logic [CountW-1:0] tok_count       = '0;
  logic              tok_letter_head = 1'b0;
  logic              tok_limit       = 1'b0;

  function automatic clt_result_t tokenize_char(input logic [CharW-1:0] c);
    clt_result_t r;
    logic        letter;
    logic        blank;
    logic        halt;
    r      = '0;
    letter = ((c >= CharUpperA) && (c <= CharUpperZ)) ||
             ((c >= CharLowerA) && (c <= CharLowerZ));
    blank  = (c == CharSpace) || (c == CharTab);
    halt   = 1'b0;
    if (c == CharNul) begin
      r.line_end = 1'b1;
      if (tok_open && !tok_limit) begin
        r.token_closed  = 1'b1;
        r.closed_length = tok_len;
        tok_count++;
      end
    end else if (!tok_limit &&
                 !(tok_leading && (blank || c == CharDollar || c == CharEquals))) begin
      tok_leading = 1'b0;
      if (blank) begin
        if (tok_open) begin
          r.token_closed  = 1'b1;
          r.closed_length = tok_len;
          tok_count++;
          tok_len  = '0;
          tok_open = 1'b0;
          if (tok_count >= MaxTokens) tok_limit = 1'b1;
        end
      end else begin
        // a letter ends a token that began with a letter
        if (tok_open && letter && tok_letter_head) begin
          r.token_closed  = 1'b1;
          r.closed_length = tok_len;
          tok_count++;
          tok_len = '0;
          if (tok_count >= MaxTokens) begin
            tok_limit = 1'b1;
            halt      = 1'b1;
          end
        end
        if (!halt && tok_len < TokenLen - 1) begin
          r.store_valid = 1'b1;
          r.store_slot  = tok_count[SlotW-1:0];
          r.store_pos   = tok_len;
          r.stored_char = c;
          if (tok_len == 0) tok_letter_head = letter;
          tok_len++;
          tok_open = 1'b1;
        end
      end
    end
    r.tokens_done = tok_count;
    if (r.line_end) begin
      tok_leading     = 1'b1;
      tok_open        = 1'b0;
      tok_len         = '0;
      tok_count       = '0;
      tok_letter_head = 1'b0;
      tok_limit       = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [CharW-1:0] pick_letter();
    if ($urandom_range(0, 1) != 0) return 8'(CharUpperA + $urandom_range(0, 25));
    return 8'(CharLowerA + $urandom_range(0, 25));
  endfunction

  function automatic logic [CharW-1:0] pick_numeric();
    string digits;
    digits = "0123456789.-+=";
    return digits[$urandom_range(0, digits.len() - 1)];
  endfunction

  function automatic logic [CharW-1:0] pick_leading();
    string lead;
    lead = "$= \t";
    return lead[$urandom_range(0, lead.len() - 1)];
  endfunction

  task automatic add_word(input logic [CharW-1:0] head, input int tail_len);
    line_chars.push_back(head);
    repeat (tail_len) line_chars.push_back(pick_numeric());
    case ($urandom_range(0, 3))
      0:       line_chars.push_back(CharSpace);
      1:       line_chars.push_back(CharTab);
      default: ;
    endcase
  endtask

  task automatic build_line(input line_kind_e kind);
    repeat ($urandom_range(0, 2)) line_chars.push_back(pick_leading());
    case (kind)
      LineWords: repeat ($urandom_range(1, 8)) add_word(pick_letter(), $urandom_range(0, 5));
      LineOverlong: begin
        // straddle the length limit, then follow with letter-headed words
        add_word(($urandom_range(0, 1) != 0) ? pick_letter() : pick_numeric(),
                 $urandom_range(29, 40));
        repeat ($urandom_range(0, 2)) add_word(pick_letter(), $urandom_range(0, 3));
      end
      LineFull: repeat ($urandom_range(15, 20)) add_word(pick_letter(), $urandom_range(0, 2));
      LineMixed: repeat ($urandom_range(1, 5)) begin
        line_chars.push_back(pick_numeric());
        repeat ($urandom_range(1, 4)) line_chars.push_back(pick_letter());
        add_word(pick_letter(), $urandom_range(0, 2));
      end
      LineNoise: repeat ($urandom_range(1, 20)) line_chars.push_back(8'($urandom_range(1, 255)));
      default: ;
    endcase
    line_chars.push_back(CharNul);
  endtask

  initial begin
    string directed;
    directed = "$= \tG1X-.5 12ab\t@[`{Zz";
    for (int i = 0; i < directed.len(); i++) line_chars.push_back(directed[i]);
    line_chars.push_back(8'hFF);
    line_chars.push_back(8'h01);
    line_chars.push_back(CharNul);
    for (int k = LineWords; k <= LineEmpty; k++) build_line(line_kind_e'(k));
    while (line_chars.size() < 440) begin
      case ($urandom_range(0, 9))
        4:       build_line(LineOverlong);
        5:       build_line(LineFull);
        6:       build_line(LineMixed);
        7:       build_line(LineNoise);
        8:       build_line(LineEmpty);
        default: build_line(LineWords);
      endcase
    end
    item_total = line_chars.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (accepted_count < item_total) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ------------------------------------------------------------------ driver

  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      char_code_i <= CharNul;
    end else begin
      if (in_fire) begin
        expected_results.push_back(tokenize_char(char_code_i));
        accepted_count++;
      end
      // hold a stalled item, otherwise advance
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0 || line_chars.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i  <= 1'b1;
          char_code_i <= line_chars.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // --------------------------------------------------------- output stalling

  stall_style_e stall_style   = StallNone;
  int           style_left    = 0;
  int           cycle_count   = 0;
  int           holdoff_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count == HoldoffAt) holdoff_left = HoldoffLen;
      if (holdoff_left > 0) begin
        // long hold-off so the block fills and stalls its input
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (style_left == 0) begin
          stall_style = stall_style_e'($urandom_range(0, 3));
          style_left  = $urandom_range(16, 96);
        end else begin
          style_left--;
        end
        case (stall_style)
          StallNone:   out_stall_i <= 1'b0;
          StallLight:  out_stall_i <= ($urandom_range(0, 3) == 0);
          StallHeavy:  out_stall_i <= ($urandom_range(0, 3) != 0);
          StallToggle: out_stall_i <= ~out_stall_i;
          default:     out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    clt_result_t want;
    if (rst_ni && out_fire) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("store_valid", want.store_valid, store_valid_o);
        compare_field("store_slot", want.store_slot, store_slot_o);
        compare_field("store_pos", want.store_pos, store_pos_o);
        compare_field("stored_char", want.stored_char, stored_char_o);
        compare_field("token_closed", want.token_closed, token_closed_o);
        compare_field("closed_length", want.closed_length, closed_length_o);
        compare_field("tokens_done", want.tokens_done, tokens_done_o);
        compare_field("line_end", want.line_end, line_end_o);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
rtl/clt_pkg.sv
rtl/clt_step.sv
rtl/command_line_tokenizer.sv
sim/command_line_tokenizer_tb.sv
